>>> rtl/core/lav_pkg.sv
// Shared constants for the look-at view matrix pipeline.
`default_nettype none
package lav_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int UNIT_W = 18;
  localparam int WORD_W = 32;
  localparam int NORM_W = 30;
  localparam int SQ_W = 2 * NORM_W + 2;
  localparam int RT_W = NORM_W + 1;
  localparam int SQRT_STEPS = SQ_W / 2;
endpackage
`default_nettype wire

>>> rtl/core/lav_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
`default_nettype none
module lav_isqrt #(
  parameter int SW = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [lav_pkg::SQ_W-1:0]    in_n,
  input  wire logic [SW-1:0]               in_side,
  output logic                             out_valid,
  output logic [lav_pkg::RT_W-1:0]         out_root,
  output logic [SW-1:0]                    out_side
);
  localparam int NS = lav_pkg::SQRT_STEPS;
  localparam int QW = lav_pkg::SQ_W;

  logic          v_r    [0:NS];
  logic [QW-1:0] n_r    [0:NS];
  logic [QW-1:0] res_r  [0:NS];
  logic [SW-1:0] side_r [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= in_n;
      res_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [QW-1:0] bit_c;
    logic [QW-1:0] trial_c;
    logic [QW-1:0] n_nxt;
    logic [QW-1:0] res_nxt;

    always_comb begin
      bit_c   = QW'(1) << (QW - 2 - 2 * k);
      trial_c = res_r[k] + bit_c;
      if (n_r[k] >= trial_c) begin
        n_nxt   = n_r[k] - trial_c;
        res_nxt = (res_r[k] >> 1) + bit_c;
      end else begin
        n_nxt   = n_r[k];
        res_nxt = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1]    <= n_nxt;
        res_r[k+1]  <= res_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[NS];
  assign out_root  = res_r[NS][lav_pkg::RT_W-1:0];
  assign out_side  = side_r[NS];
endmodule
`default_nettype wire

>>> rtl/core/lav_unit3.sv
// Pipelined 3-vector normalizer: scale, sum of squares, root, restoring divide.
`default_nettype none
module lav_unit3 #(
  parameter int MW = 33,
  parameter int FRAC = 16,
  parameter int SW = 1,
  localparam int QW = FRAC + 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [2:0]           in_neg,
  input  wire logic [2:0][MW-1:0]   in_mag,
  input  wire logic [SW-1:0]        in_side,
  output logic                      out_valid,
  output logic [2:0][QW-1:0]        out_q,
  output logic [SW-1:0]             out_side
);
  localparam int NW = lav_pkg::NORM_W;
  localparam int PW = $clog2(MW);
  localparam int RW = NW + FRAC + 1;
  localparam int XW = 3 * NW + 4 + SW;
  localparam int LW = lav_pkg::RT_W;
  localparam int DS = FRAC + 1;

  function automatic logic [PW-1:0] lead_pos(input logic [MW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) begin
      if (x[i]) p = PW'(i);
    end
    return p;
  endfunction

  // stage A: inputs
  logic                va_r;
  logic [2:0]          nega_r;
  logic [2:0][MW-1:0]  maga_r;
  logic [SW-1:0]       sidea_r;
  // stage B: leading position
  logic                vb_r;
  logic [2:0]          negb_r;
  logic                zb_r;
  logic [PW-1:0]       pb_r;
  logic [2:0][MW-1:0]  magb_r;
  logic [SW-1:0]       sideb_r;
  // stage C: scaled magnitudes
  logic                vc_r;
  logic [2:0]          negc_r;
  logic                zc_r;
  logic [2:0][NW-1:0]  nmc_r;
  logic [SW-1:0]       sidec_r;
  // stage D: squares
  logic                vd_r;
  logic [2:0]          negd_r;
  logic                zd_r;
  logic [2:0][NW-1:0]  nmd_r;
  logic [2*NW-1:0]     sqd_r [3];
  logic [SW-1:0]       sided_r;

  logic [MW-1:0]         or_c;
  logic [2:0][NW-1:0]    nm_c;
  logic [2*NW-1:0]       sq_c [3];
  logic [lav_pkg::SQ_W-1:0] n_c;

  logic                  sq_v;
  logic [LW-1:0]         sq_root;
  logic [XW-1:0]         sq_side;
  logic [2:0][NW-1:0]    sq_nm;

  logic          dv_r    [0:DS];
  logic [RW-1:0] drem_r  [0:DS][3];
  logic [LW-1:0] dlen_r  [0:DS];
  logic [DS-1:0] dq_r    [0:DS][3];
  logic [2:0]    dneg_r  [0:DS];
  logic          dz_r    [0:DS];
  logic [SW-1:0] dside_r [0:DS];

  always_comb begin
    or_c = maga_r[0] | maga_r[1] | maga_r[2];
  end

  always_comb begin
    logic [MW+NW-1:0] wide;
    for (int l = 0; l < 3; l++) begin
      wide = (MW+NW)'(magb_r[l]);
      if (pb_r >= PW'(NW - 1)) begin
        wide = wide >> (pb_r - PW'(NW - 1));
      end else begin
        wide = wide << (PW'(NW - 1) - pb_r);
      end
      nm_c[l] = wide[NW-1:0];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sq_c[l] = (2*NW)'(nmc_r[l]) * (2*NW)'(nmc_r[l]);
    end
    n_c = lav_pkg::SQ_W'(sqd_r[0]) + lav_pkg::SQ_W'(sqd_r[1])
        + lav_pkg::SQ_W'(sqd_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nega_r  <= in_neg;
      maga_r  <= in_mag;
      sidea_r <= in_side;
      negb_r  <= nega_r;
      zb_r    <= (or_c == '0);
      pb_r    <= lead_pos(or_c);
      magb_r  <= maga_r;
      sideb_r <= sidea_r;
      negc_r  <= negb_r;
      zc_r    <= zb_r;
      nmc_r   <= nm_c;
      sidec_r <= sideb_r;
      negd_r  <= negc_r;
      zd_r    <= zc_r;
      nmd_r   <= nmc_r;
      for (int l = 0; l < 3; l++) sqd_r[l] <= sq_c[l];
      sided_r <= sidec_r;
    end
  end

  lav_isqrt #(
    .SW(XW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vd_r),
    .in_n      (n_c),
    .in_side   ({nmd_r, negd_r, zd_r, sided_r}),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign sq_nm = sq_side[XW-1 -: 3*NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        drem_r[0][l] <= RW'(sq_nm[l]) << FRAC;
        dq_r[0][l]   <= '0;
      end
      dlen_r[0]  <= sq_root;
      dneg_r[0]  <= sq_side[SW+1 +: 3];
      dz_r[0]    <= sq_side[SW];
      dside_r[0] <= sq_side[SW-1:0];
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [RW-1:0] trial_c;
    logic [RW-1:0] rem_nxt [3];
    logic [DS-1:0] q_nxt   [3];

    always_comb begin
      trial_c = RW'(dlen_r[k]) << (FRAC - k);
      for (int l = 0; l < 3; l++) begin
        if (drem_r[k][l] >= trial_c) begin
          rem_nxt[l] = drem_r[k][l] - trial_c;
          q_nxt[l]   = dq_r[k][l] | (DS'(1) << (FRAC - k));
        end else begin
          rem_nxt[l] = drem_r[k][l];
          q_nxt[l]   = dq_r[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          drem_r[k+1][l] <= rem_nxt[l];
          dq_r[k+1][l]   <= q_nxt[l];
        end
        dlen_r[k+1]  <= dlen_r[k];
        dneg_r[k+1]  <= dneg_r[k];
        dz_r[k+1]    <= dz_r[k];
        dside_r[k+1] <= dside_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (dz_r[DS]) begin
          out_q[l] <= '0;
        end else if (dneg_r[DS][l]) begin
          out_q[l] <= QW'(-QW'(dq_r[DS][l]));
        end else begin
          out_q[l] <= QW'(dq_r[DS][l]);
        end
      end
      out_side <= dside_r[DS];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix pipeline.
// Takes one camera setup (eye, target, up) per cycle unless stalled and returns
// side, true up, negated forward and saturated translations in fixed point with
// FRAC_BITS fraction bits. Between input and output the data runs through
// two normalizer pipelines, each a 31-stage square root and a FRAC_BITS+1 stage
// restoring divider. Throughput is one transfer per cycle; the pipeline stalls
// as a whole only while the output register holds a result that is not taken
// and the last stage is full; while the last stage is empty, slots keep moving.
`default_nettype none
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_eye_x,
  input  wire logic [31:0] in_eye_y,
  input  wire logic [31:0] in_eye_z,
  input  wire logic [31:0] in_target_x,
  input  wire logic [31:0] in_target_y,
  input  wire logic [31:0] in_target_z,
  input  wire logic [31:0] in_upward_x,
  input  wire logic [31:0] in_upward_y,
  input  wire logic [31:0] in_upward_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [17:0]      out_right_x,
  output logic [17:0]      out_right_y,
  output logic [17:0]      out_right_z,
  output logic [17:0]      out_cam_up_x,
  output logic [17:0]      out_cam_up_y,
  output logic [17:0]      out_cam_up_z,
  output logic [17:0]      out_back_x,
  output logic [17:0]      out_back_y,
  output logic [17:0]      out_back_z,
  output logic [31:0]      out_shift_x,
  output logic [31:0]      out_shift_y,
  output logic [31:0]      out_shift_z
);
  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 2;
  localparam int CW  = QW + 33;
  localparam int CMW = QW + 32;
  localparam int UW  = QW + 1;
  localparam int EW  = 72;
  localparam int WW  = lav_pkg::WORD_W;
  localparam int UNW = lav_pkg::UNIT_W;
  localparam int SWA = 6 * WW;
  localparam int SWB = 3 * QW + 3 * WW;

  function automatic logic signed [EW-1:0] rnd(input logic signed [EW-1:0] x);
    logic [EW-1:0] m;
    m = x[EW-1] ? EW'(-x) : EW'(x);
    m = (m + (EW'(1) << (F - 1))) >> F;
    return x[EW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [WW-1:0] sat(input logic signed [EW-1:0] x);
    if (x > $signed(EW'(32'h7fff_ffff))) return 32'h7fff_ffff;
    if (x < -$signed(EW'(32'h8000_0000))) return 32'h8000_0000;
    return x[WW-1:0];
  endfunction

  function automatic logic [UNW-1:0] unit_bits(input logic signed [EW-1:0] x);
    return x[UNW-1:0];
  endfunction

  logic out_load;
  logic en;
  logic p7_v_r;

  assign out_load = !out_valid || out_ready;
  assign en       = out_load || !p7_v_r;
  assign in_ready = en;

  // stage 0: eye to target difference
  logic [WW-1:0] in_eye [3];
  logic [WW-1:0] in_tgt [3];
  logic [WW-1:0] in_up  [3];
  logic signed [WW:0] d_c [3];

  assign in_eye = '{in_eye_x, in_eye_y, in_eye_z};
  assign in_tgt = '{in_target_x, in_target_y, in_target_z};
  assign in_up  = '{in_upward_x, in_upward_y, in_upward_z};

  logic                 p0_v_r;
  logic [2:0]           p0_neg_r;
  logic [2:0][WW:0]     p0_mag_r;
  logic [SWA-1:0]       p0_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = $signed({in_tgt[i][WW-1], in_tgt[i]}) - $signed({in_eye[i][WW-1], in_eye[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p0_neg_r[i] <= d_c[i][WW];
        p0_mag_r[i] <= d_c[i][WW] ? (WW+1)'(-d_c[i]) : (WW+1)'(d_c[i]);
      end
      p0_side_r <= {in_eye[0], in_eye[1], in_eye[2], in_up[0], in_up[1], in_up[2]};
    end
  end

  // forward vector
  logic              ua_v;
  logic [2:0][QW-1:0] ua_q;
  logic [SWA-1:0]    ua_side;

  lav_unit3 #(
    .MW   (WW + 1),
    .FRAC (F),
    .SW   (SWA)
  ) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p0_v_r),
    .in_neg    (p0_neg_r),
    .in_mag    (p0_mag_r),
    .in_side   (p0_side_r),
    .out_valid (ua_v),
    .out_q     (ua_q),
    .out_side  (ua_side)
  );

  logic signed [QW-1:0]    fa [3];
  logic signed [WW-1:0]    ea [3];
  logic signed [WW-1:0]    upa [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fa[i]  = $signed(ua_q[i]);
      ea[i]  = $signed(ua_side[SWA-1-WW*i -: WW]);
      upa[i] = $signed(ua_side[3*WW-1-WW*i -: WW]);
    end
  end

  // stage 1: forward x up products; stage 2: differences
  logic                    p1_v_r;
  logic signed [QW+WW-1:0] p1_pr_r [6];
  logic signed [QW-1:0]    p1_f_r  [3];
  logic signed [WW-1:0]    p1_e_r  [3];
  logic                    p2_v_r;
  logic signed [CW-1:0]    p2_c_r  [3];
  logic signed [QW-1:0]    p2_f_r  [3];
  logic signed [WW-1:0]    p2_e_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pr_r[0] <= fa[1] * upa[2];
      p1_pr_r[1] <= fa[2] * upa[1];
      p1_pr_r[2] <= fa[2] * upa[0];
      p1_pr_r[3] <= fa[0] * upa[2];
      p1_pr_r[4] <= fa[0] * upa[1];
      p1_pr_r[5] <= fa[1] * upa[0];
      p1_f_r <= fa;
      p1_e_r <= ea;
      for (int i = 0; i < 3; i++) begin
        p2_c_r[i] <= CW'(p1_pr_r[2*i]) - CW'(p1_pr_r[2*i+1]);
      end
      p2_f_r <= p1_f_r;
      p2_e_r <= p1_e_r;
    end
  end

  logic [2:0]          cb_neg;
  logic [2:0][CMW-1:0] cb_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cb_neg[i] = p2_c_r[i][CW-1];
      cb_mag[i] = p2_c_r[i][CW-1] ? CMW'(-p2_c_r[i]) : CMW'(p2_c_r[i]);
    end
  end

  // side vector
  logic               ub_v;
  logic [2:0][QW-1:0] ub_q;
  logic [SWB-1:0]     ub_side;

  lav_unit3 #(
    .MW   (CMW),
    .FRAC (F),
    .SW   (SWB)
  ) u_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p2_v_r),
    .in_neg    (cb_neg),
    .in_mag    (cb_mag),
    .in_side   ({p2_f_r[0], p2_f_r[1], p2_f_r[2], p2_e_r[0], p2_e_r[1], p2_e_r[2]}),
    .out_valid (ub_v),
    .out_q     (ub_q),
    .out_side  (ub_side)
  );

  logic signed [QW-1:0] sb [3];
  logic signed [QW-1:0] fb [3];
  logic signed [WW-1:0] eb [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sb[i] = $signed(ub_q[i]);
      fb[i] = $signed(ub_side[SWB-1-QW*i -: QW]);
      eb[i] = $signed(ub_side[3*WW-1-WW*i -: WW]);
    end
  end

  // stages 3..7: true up, dot products, rounding
  logic                    p3_v_r;
  logic signed [2*QW-1:0]  p3_xp_r [6];
  logic signed [QW+WW-1:0] p3_se_r [3];
  logic signed [QW+WW-1:0] p3_fe_r [3];
  logic signed [QW-1:0]    p3_s_r  [3];
  logic signed [QW-1:0]    p3_f_r  [3];
  logic signed [WW-1:0]    p3_e_r  [3];

  logic                    p4_v_r;
  logic signed [2*QW:0]    p4_cu_r [3];
  logic signed [QW+WW+1:0] p4_sd_r;
  logic signed [QW+WW+1:0] p4_fd_r;
  logic signed [QW-1:0]    p4_s_r  [3];
  logic signed [QW-1:0]    p4_f_r  [3];
  logic signed [WW-1:0]    p4_e_r  [3];

  logic                    p5_v_r;
  logic signed [UW-1:0]    p5_u_r  [3];
  logic [WW-1:0]           p5_shx_r;
  logic [WW-1:0]           p5_shz_r;
  logic signed [QW-1:0]    p5_s_r  [3];
  logic signed [QW-1:0]    p5_f_r  [3];
  logic signed [WW-1:0]    p5_e_r  [3];

  logic                    p6_v_r;
  logic signed [UW+WW-1:0] p6_ue_r [3];
  logic signed [UW-1:0]    p6_u_r  [3];
  logic [WW-1:0]           p6_shx_r;
  logic [WW-1:0]           p6_shz_r;
  logic signed [QW-1:0]    p6_s_r  [3];
  logic signed [QW-1:0]    p6_f_r  [3];

  logic signed [UW+WW+1:0] p7_ud_r;
  logic signed [UW-1:0]    p7_u_r  [3];
  logic [WW-1:0]           p7_shx_r;
  logic [WW-1:0]           p7_shz_r;
  logic signed [QW-1:0]    p7_s_r  [3];
  logic signed [QW-1:0]    p7_f_r  [3];

  logic signed [EW-1:0] u_rnd_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_rnd_c[i] = rnd(EW'(p4_cu_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_xp_r[0] <= sb[1] * fb[2];
      p3_xp_r[1] <= sb[2] * fb[1];
      p3_xp_r[2] <= sb[2] * fb[0];
      p3_xp_r[3] <= sb[0] * fb[2];
      p3_xp_r[4] <= sb[0] * fb[1];
      p3_xp_r[5] <= sb[1] * fb[0];
      for (int i = 0; i < 3; i++) begin
        p3_se_r[i] <= sb[i] * eb[i];
        p3_fe_r[i] <= fb[i] * eb[i];
      end
      p3_s_r <= sb;
      p3_f_r <= fb;
      p3_e_r <= eb;

      for (int i = 0; i < 3; i++) begin
        p4_cu_r[i] <= (2*QW+1)'(p3_xp_r[2*i]) - (2*QW+1)'(p3_xp_r[2*i+1]);
      end
      p4_sd_r <= (QW+WW+2)'(p3_se_r[0]) + (QW+WW+2)'(p3_se_r[1])
               + (QW+WW+2)'(p3_se_r[2]);
      p4_fd_r <= (QW+WW+2)'(p3_fe_r[0]) + (QW+WW+2)'(p3_fe_r[1])
               + (QW+WW+2)'(p3_fe_r[2]);
      p4_s_r <= p3_s_r;
      p4_f_r <= p3_f_r;
      p4_e_r <= p3_e_r;

      for (int i = 0; i < 3; i++) begin
        p5_u_r[i] <= UW'(u_rnd_c[i]);
      end
      p5_shx_r <= sat(-rnd(EW'(p4_sd_r)));
      p5_shz_r <= sat(rnd(EW'(p4_fd_r)));
      p5_s_r <= p4_s_r;
      p5_f_r <= p4_f_r;
      p5_e_r <= p4_e_r;

      for (int i = 0; i < 3; i++) begin
        p6_ue_r[i] <= p5_u_r[i] * p5_e_r[i];
      end
      p6_u_r   <= p5_u_r;
      p6_shx_r <= p5_shx_r;
      p6_shz_r <= p5_shz_r;
      p6_s_r   <= p5_s_r;
      p6_f_r   <= p5_f_r;

      p7_ud_r <= (UW+WW+2)'(p6_ue_r[0]) + (UW+WW+2)'(p6_ue_r[1])
               + (UW+WW+2)'(p6_ue_r[2]);
      p7_u_r   <= p6_u_r;
      p7_shx_r <= p6_shx_r;
      p7_shz_r <= p6_shz_r;
      p7_s_r   <= p6_s_r;
      p7_f_r   <= p6_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
      p6_v_r <= 1'b0;
      p7_v_r <= 1'b0;
    end else if (en) begin
      p0_v_r <= in_valid;
      p1_v_r <= ua_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= ub_v;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
      p6_v_r <= p5_v_r;
      p7_v_r <= p6_v_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= p7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_right_x  <= unit_bits(EW'(p7_s_r[0]));
      out_right_y  <= unit_bits(EW'(p7_s_r[1]));
      out_right_z  <= unit_bits(EW'(p7_s_r[2]));
      out_cam_up_x <= unit_bits(EW'(p7_u_r[0]));
      out_cam_up_y <= unit_bits(EW'(p7_u_r[1]));
      out_cam_up_z <= unit_bits(EW'(p7_u_r[2]));
      out_back_x   <= unit_bits(-EW'(p7_f_r[0]));
      out_back_y   <= unit_bits(-EW'(p7_f_r[1]));
      out_back_z   <= unit_bits(-EW'(p7_f_r[2]));
      out_shift_x  <= p7_shx_r;
      out_shift_y  <= sat(-rnd(EW'(p7_ud_r)));
      out_shift_z  <= p7_shz_r;
    end
  end
endmodule
`default_nettype wire
